// ===== hdl/ihalu_pkg.sv =====
// ihalu_pkg: shared types, constants and helper functions for the integer helper ALU.
// Used by ihalu_zcnt and integer_helper_alu_unit; depends on nothing.
package ihalu_pkg;

  localparam int DATA_W = 64;
  localparam int SIZE_W = 7;
  localparam int OP_W   = 3;
  localparam int CNT_W  = 6;
  localparam int POS_W  = 6;
  localparam int HALF_W = DATA_W / 2;

  typedef enum logic [OP_W-1:0] {
    OP_MUL_LO = 3'd0,
    OP_MUL_HI = 3'd1,
    OP_ROL    = 3'd2,
    OP_ROR    = 3'd3,
    OP_CLZ    = 3'd4,
    OP_CTZ    = 3'd5
  } op_t;

  // Leading/trailing one positions of a word.
  typedef struct packed {
    logic             any;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] lo;
  } zcnt_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    m = '1;
    if (sz < SIZE_W'(DATA_W)) begin
      m = ~({DATA_W{1'b1}} << sz);
    end
    return m;
  endfunction

  function automatic logic mul_size_ok(input logic [SIZE_W-1:0] sz);
    return sz inside {7'd8, 7'd16, 7'd32};
  endfunction

  function automatic logic rot_size_ok(input logic [SIZE_W-1:0] sz);
    return sz inside {7'd8, 7'd16, 7'd32, 7'd64, 7'd9, 7'd17, 7'd33};
  endfunction

  // Count mod size for a 6-bit count; seven conditional subtracts cover size 8 and up.
  function automatic logic [CNT_W-1:0] count_mod(input logic [CNT_W-1:0] cnt,
                                                input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] c;
    c = {1'b0, cnt};
    for (int i = 0; i < 7; i++) begin
      if (c >= sz) begin
        c = SIZE_W'(c - sz);
      end
    end
    return c[CNT_W-1:0];
  endfunction

endpackage

// ===== hdl/integer_helper_alu_unit.sv =====
// integer_helper_alu_unit: multiply / rotate / count-zeros helper unit, three-stage pipeline.
// Throughput one item per cycle while out_ready keeps the output moving.
// Each stage takes a new item as its old one moves on; stage 2 (32x32 multiplier, rotators
// and 64-bit bit search) is the deepest and sets the clock period, not the item rate.
// Reset (rst, synchronous) clears the stage valid bits only; data registers are not reset.
// Depends on ihalu_pkg and ihalu_zcnt.
module integer_helper_alu_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ihalu_pkg::OP_W-1:0]    op,
  input  logic [ihalu_pkg::SIZE_W-1:0]  size,
  input  logic [ihalu_pkg::DATA_W-1:0]  operand_a,
  input  logic [ihalu_pkg::DATA_W-1:0]  operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ihalu_pkg::DATA_W-1:0]  result,
  output logic                          invalid_size
);
  import ihalu_pkg::*;

  // Stage valid bits, one per register stage (out_valid is the third).
  logic s1_valid;
  logic s2_valid;

  // Stall chain: a stage takes a new item when it is empty or its item moves on.
  logic r1, r2, r3;
  assign r3       = !out_valid || out_ready;
  assign r2       = !s2_valid || r3;
  assign r1       = !s1_valid || r2;
  assign in_ready = r1;

  // ---------------- Stage 1: decode, size checks, operand masking, count reduction
  op_t               s1_op;
  logic [SIZE_W-1:0] s1_size;
  logic [DATA_W-1:0] s1_mask;
  logic [DATA_W-1:0] s1_a;
  logic [HALF_W-1:0] s1_b;
  logic [CNT_W-1:0]  s1_cnt;
  logic              s1_bad;

  logic [DATA_W-1:0] mask_next;
  logic              bad_next;
  op_t               op_next;

  always_comb begin
    op_next   = op_t'(op);
    mask_next = width_mask(size);
    case (op_next)
      OP_MUL_LO, OP_MUL_HI: bad_next = !mul_size_ok(size);
      OP_ROL, OP_ROR:       bad_next = !rot_size_ok(size);
      OP_CLZ, OP_CTZ:       bad_next = (size > SIZE_W'(DATA_W));
      default:              bad_next = 1'b1;  // unused op codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (r1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      s1_op   <= op_next;
      s1_size <= size;
      s1_mask <= mask_next;
      s1_a    <= operand_a & mask_next;
      // Multiplies only run at 32 bits or less, so the low half of b is enough.
      s1_b    <= operand_b[HALF_W-1:0] & mask_next[HALF_W-1:0];
      // Count mod size only matters for valid rotate sizes.
      s1_cnt  <= rot_size_ok(size) ? count_mod(operand_b[CNT_W-1:0], size) : '0;
      s1_bad  <= bad_next;
    end
  end

  // ---------------- Stage 2: multiply, rotate, bit search
  op_t               s2_op;
  logic [SIZE_W-1:0] s2_size;
  logic [DATA_W-1:0] s2_mask;
  logic [DATA_W-1:0] s2_prod;
  logic [DATA_W-1:0] s2_rot;
  zcnt_t             s2_zc;
  logic              s2_bad;

  logic [DATA_W-1:0] prod_next;
  logic [DATA_W-1:0] rot_next;
  logic [SIZE_W-1:0] back_amt;
  zcnt_t             zc_next;

  ihalu_zcnt u_zcnt (
    .val (s1_a),
    .zc  (zc_next)
  );

  always_comb begin
    prod_next = s1_a[HALF_W-1:0] * s1_b;
    // s1_a is already masked; a zero count moves the wrap-around part wholly outside the low size bits.
    back_amt  = SIZE_W'(s1_size - {1'b0, s1_cnt});
    if (s1_op == OP_ROL) begin
      rot_next = (s1_a << s1_cnt) | (s1_a >> back_amt);
    end else begin
      rot_next = (s1_a >> s1_cnt) | (s1_a << back_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (r2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && r2) begin
      s2_op   <= s1_op;
      s2_size <= s1_size;
      s2_mask <= s1_mask;
      s2_prod <= prod_next;
      s2_rot  <= rot_next;
      s2_zc   <= zc_next;
      s2_bad  <= s1_bad;
    end
  end

  // ---------------- Stage 3: pick and mask the result; this is the output register
  logic [DATA_W-1:0] res_next;

  always_comb begin
    case (s2_op)
      OP_MUL_LO: res_next = s2_prod & s2_mask;
      OP_MUL_HI: res_next = (s2_prod >> s2_size) & s2_mask;
      OP_ROL,
      OP_ROR:    res_next = s2_rot & s2_mask;
      OP_CLZ:    res_next = s2_zc.any ?
                   DATA_W'(SIZE_W'(s2_size - 7'd1 - {1'b0, s2_zc.hi})) : DATA_W'(s2_size);
      OP_CTZ:    res_next = s2_zc.any ? DATA_W'(s2_zc.lo) : DATA_W'(s2_size);
      default:   res_next = '0;
    endcase
    if (s2_bad) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && r3) begin
      result       <= res_next;
      invalid_size <= s2_bad;
    end
  end

`ifndef NO_ASSERTIONS
  // A flagged item always carries a zero result.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid_size |-> result == '0)
    else $error("invalid_size item with nonzero result");

  // Input is only held off when every stage is occupied (no bubbles in a stall).
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s2_valid && out_valid)
    else $error("input stalled with an empty stage");

  // Highest set bit never sits below the lowest.
  a_zc_order: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_zc.any |-> s2_zc.hi >= s2_zc.lo)
    else $error("bit search order broken");
`endif

endmodule

// ===== hdl/ihalu_zcnt.sv =====
// ihalu_zcnt: finds the highest and lowest set bit of a 64-bit word.
// Two-level byte search. Depends on ihalu_pkg.
module ihalu_zcnt (
  input  logic [ihalu_pkg::DATA_W-1:0] val,
  output ihalu_pkg::zcnt_t             zc
);
  import ihalu_pkg::*;

  localparam int GRP = DATA_W / 8;

  logic [GRP-1:0] nz;
  logic [2:0]     hi_b [GRP];
  logic [2:0]     lo_b [GRP];
  logic [2:0]     hg;
  logic [2:0]     lg;

  always_comb begin
    for (int g = 0; g < GRP; g++) begin
      nz[g]   = |val[8*g +: 8];
      hi_b[g] = 3'd0;
      lo_b[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (val[8*g + b]) begin
          hi_b[g] = 3'(b);
        end
      end
      for (int b = 7; b >= 0; b--) begin
        if (val[8*g + b]) begin
          lo_b[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    hg = 3'd0;
    lg = 3'd0;
    for (int g = 0; g < GRP; g++) begin
      if (nz[g]) begin
        hg = 3'(g);
      end
    end
    for (int g = GRP - 1; g >= 0; g--) begin
      if (nz[g]) begin
        lg = 3'(g);
      end
    end
    zc.any = |nz;
    zc.hi  = {hg, hi_b[hg]};
    zc.lo  = {lg, lo_b[lg]};
  end

endmodule
